FILE: design/pnhm_pkg.sv
package pnhm_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_SECOND  = 2'd1,
        OP_MESSAGE = 2'd2
    } t_opcode;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_WAITING_PERIODS    = 3'd0,
        REG_STUCK_MIN_POSITION = 3'd1,
        REG_STUCK_SAMPLE_LIMIT = 3'd2,
        REG_POT_SUM_LOW        = 3'd3,
        REG_POT_SUM_HIGH       = 3'd4,
        REG_TEMP_LIMIT         = 3'd5
    } t_reg_idx;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Message identifiers
    localparam logic [10:0] ID_REAR = 11'h202;
    localparam logic [10:0] ID_TEMP = 11'h050;

    // Accelerator clamp and stuck counter ceiling
    localparam logic [7:0] ACCEL_CLAMP = 8'd200;
    localparam logic [7:0] STUCK_SAT   = 8'd130;

    // Configuration reset values
    localparam logic [6:0]  RST_WAITING_PERIODS    = 7'd5;
    localparam logic [7:0]  RST_STUCK_MIN_POSITION = 8'd60;
    localparam logic [7:0]  RST_STUCK_SAMPLE_LIMIT = 8'd120;
    localparam logic [10:0] RST_POT_SUM_LOW        = 11'd723;
    localparam logic [10:0] RST_POT_SUM_HIGH       = 11'd1323;
    localparam logic [15:0] RST_TEMP_LIMIT         = 16'd600;

    // Error byte bit positions
    localparam int unsigned ERR_PLAUS      = 0;
    localparam int unsigned ERR_STUCK      = 1;
    localparam int unsigned ERR_OVERTEMP   = 2;
    localparam int unsigned ERR_LIGHT_TO   = 3;
    localparam int unsigned ERR_REAR_LO    = 4;
    localparam int unsigned ERR_REAR_HI    = 5;
    localparam int unsigned ERR_REAR_TO    = 6;
    localparam int unsigned ERR_TEMP_TO    = 7;

    // Reciprocal of five in 2^-10 units; exact for every 10-bit value
    localparam logic [7:0] DIV5_MUL = 8'd205;

    // Divide a 10-bit reading by five
    function automatic logic [7:0] div5(input logic [9:0] value);
        logic [17:0] prod;
        prod = 18'(value) * 18'(DIV5_MUL);
        return prod[17:10];
    endfunction

endpackage

FILE: design/pedal_and_node_health_monitor_top.sv
// Pedal and node health monitor. One item transfers per clock unless stalled: a
// sample tick (opcode 0) produces one result in the output register on the
// next cycle, while one-second ticks (opcode 1) and received messages (opcode
// 2) update the heartbeat counters and error byte and produce no result;
// opcode 3 is ignored. All state updates at the input transfer edge, so
// back-to-back items see each other's effects, and the single output register
// lets a new item transfer while a result still waits, as long as that result
// is taken in the same cycle. Configuration is an APB-style port with registers
// at byte addresses 0x00 to 0x14 and should only be written while idle.
module pedal_and_node_health_monitor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_accel_pot_a,
    input  logic [9:0]  i_accel_pot_b,
    input  logic [9:0]  i_brake_pot,
    input  logic [9:0]  i_brake_level_pot,
    input  logic [10:0] i_message_id,
    input  logic [7:0]  i_data_first,
    input  logic [7:0]  i_data_second,

    // Result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_accel_position,
    output logic [7:0]  o_brake_position,
    output logic [7:0]  o_error_bits,
    output logic        o_brake_light_on,

    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pnhm_pkg::ADDR_W-1:0]   paddr,
    input  logic [pnhm_pkg::DATA_W-1:0]   pwdata,
    output logic [pnhm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    // Configuration registers
    logic [6:0]  r_waiting_periods;
    logic [7:0]  r_stuck_min_position;
    logic [7:0]  r_stuck_sample_limit;
    logic [10:0] r_pot_sum_low;
    logic [10:0] r_pot_sum_high;
    logic [15:0] r_temp_limit;

    // Monitor state
    logic [7:0]  r_previous_accel,  n_previous_accel;
    logic [7:0]  r_stuck_samples,   n_stuck_samples;
    logic        r_light_state,     n_light_state;
    logic [7:0]  r_error_store,     n_error_store;
    logic [6:0]  r_rear_heartbeat,  n_rear_heartbeat;
    logic [6:0]  r_temp_heartbeat,  n_temp_heartbeat;
    logic [6:0]  r_light_heartbeat, n_light_heartbeat;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_accel;
    logic [7:0]  r_out_brake;

    logic                 in_xfer;
    logic                 cfg_write;
    pnhm_pkg::t_opcode    op;
    pnhm_pkg::t_reg_idx   reg_idx;
    logic [7:0]           accel_div;
    logic [7:0]           accel_scaled;
    logic [7:0]           brake_scaled;
    logic [8:0]           stuck_inc;
    logic [10:0]          pot_sum;
    logic [15:0]          temp_value;
    logic                 sample_xfer;

    assign op       = pnhm_pkg::t_opcode'(i_opcode);
    assign reg_idx  = pnhm_pkg::t_reg_idx'(paddr[4:2]);
    assign o_ready  = !r_out_valid || i_ready;
    assign in_xfer  = i_valid && o_ready;
    assign sample_xfer = in_xfer && (op == pnhm_pkg::OP_SAMPLE);
    assign pready   = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Scale pedal readings
    assign accel_div    = pnhm_pkg::div5(i_accel_pot_a);
    assign accel_scaled = (accel_div > pnhm_pkg::ACCEL_CLAMP) ? pnhm_pkg::ACCEL_CLAMP
                                                              : accel_div;
    assign brake_scaled = pnhm_pkg::div5(i_brake_pot);
    assign pot_sum      = {1'b0, i_accel_pot_a} + {1'b0, i_accel_pot_b};
    assign temp_value   = {i_data_first, i_data_second};
    assign stuck_inc    = {1'b0, r_stuck_samples} + 9'd1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting_periods    <= pnhm_pkg::RST_WAITING_PERIODS;
            r_stuck_min_position <= pnhm_pkg::RST_STUCK_MIN_POSITION;
            r_stuck_sample_limit <= pnhm_pkg::RST_STUCK_SAMPLE_LIMIT;
            r_pot_sum_low        <= pnhm_pkg::RST_POT_SUM_LOW;
            r_pot_sum_high       <= pnhm_pkg::RST_POT_SUM_HIGH;
            r_temp_limit         <= pnhm_pkg::RST_TEMP_LIMIT;
        end else if (cfg_write) begin
            unique case (reg_idx)
                pnhm_pkg::REG_WAITING_PERIODS:    r_waiting_periods    <= pwdata[6:0];
                pnhm_pkg::REG_STUCK_MIN_POSITION: r_stuck_min_position <= pwdata[7:0];
                pnhm_pkg::REG_STUCK_SAMPLE_LIMIT: r_stuck_sample_limit <= pwdata[7:0];
                pnhm_pkg::REG_POT_SUM_LOW:        r_pot_sum_low        <= pwdata[10:0];
                pnhm_pkg::REG_POT_SUM_HIGH:       r_pot_sum_high       <= pwdata[10:0];
                pnhm_pkg::REG_TEMP_LIMIT:         r_temp_limit         <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (reg_idx)
            pnhm_pkg::REG_WAITING_PERIODS:    prdata = 32'(r_waiting_periods);
            pnhm_pkg::REG_STUCK_MIN_POSITION: prdata = 32'(r_stuck_min_position);
            pnhm_pkg::REG_STUCK_SAMPLE_LIMIT: prdata = 32'(r_stuck_sample_limit);
            pnhm_pkg::REG_POT_SUM_LOW:        prdata = 32'(r_pot_sum_low);
            pnhm_pkg::REG_POT_SUM_HIGH:       prdata = 32'(r_pot_sum_high);
            pnhm_pkg::REG_TEMP_LIMIT:         prdata = 32'(r_temp_limit);
            default:                          prdata = '0;
        endcase
    end

    // Compute next monitor state for the transferred item
    always_comb begin
        n_previous_accel  = r_previous_accel;
        n_stuck_samples   = r_stuck_samples;
        n_light_state     = r_light_state;
        n_error_store     = r_error_store;
        n_rear_heartbeat  = r_rear_heartbeat;
        n_temp_heartbeat  = r_temp_heartbeat;
        n_light_heartbeat = r_light_heartbeat;
        if (in_xfer) begin
            unique case (op)
                pnhm_pkg::OP_SAMPLE: begin
                    n_light_state = (i_brake_pot > i_brake_level_pot);
                    // Count unchanged samples above the minimum position
                    if (accel_scaled == r_previous_accel &&
                        accel_scaled > r_stuck_min_position) begin
                        n_error_store[pnhm_pkg::ERR_STUCK] =
                            (stuck_inc > {1'b0, r_stuck_sample_limit});
                        n_stuck_samples = (stuck_inc[7:0] > pnhm_pkg::STUCK_SAT)
                                        ? pnhm_pkg::STUCK_SAT : stuck_inc[7:0];
                    end else begin
                        n_error_store[pnhm_pkg::ERR_STUCK] = 1'b0;
                        n_stuck_samples = '0;
                    end
                    n_previous_accel = accel_scaled;
                    n_error_store[pnhm_pkg::ERR_PLAUS] =
                        (pot_sum < r_pot_sum_low) || (pot_sum > r_pot_sum_high);
                end
                pnhm_pkg::OP_SECOND: begin
                    // Count down heartbeats, flag timeout at zero
                    if (r_rear_heartbeat == '0) begin
                        n_error_store[pnhm_pkg::ERR_REAR_TO] = 1'b1;
                    end else begin
                        n_rear_heartbeat = r_rear_heartbeat - 7'd1;
                        n_error_store[pnhm_pkg::ERR_REAR_TO] = 1'b0;
                    end
                    if (r_temp_heartbeat == '0) begin
                        n_error_store[pnhm_pkg::ERR_TEMP_TO] = 1'b1;
                    end else begin
                        n_temp_heartbeat = r_temp_heartbeat - 7'd1;
                        n_error_store[pnhm_pkg::ERR_TEMP_TO] = 1'b0;
                    end
                    if (r_light_heartbeat == '0) begin
                        n_error_store[pnhm_pkg::ERR_LIGHT_TO] = 1'b1;
                    end else begin
                        n_light_heartbeat = r_light_heartbeat - 7'd1;
                        n_error_store[pnhm_pkg::ERR_LIGHT_TO] = 1'b0;
                    end
                end
                pnhm_pkg::OP_MESSAGE: begin
                    if (i_message_id == pnhm_pkg::ID_REAR) begin
                        n_rear_heartbeat = r_waiting_periods;
                        n_error_store[pnhm_pkg::ERR_REAR_LO] = i_data_first[1];
                        n_error_store[pnhm_pkg::ERR_REAR_HI] = i_data_first[2];
                        // Reload light heartbeat only when the rear node agrees
                        if (r_light_state == i_data_first[0]) begin
                            n_light_heartbeat = r_waiting_periods;
                        end
                    end
                    if (i_message_id == pnhm_pkg::ID_TEMP) begin
                        n_temp_heartbeat = r_waiting_periods;
                        n_error_store[pnhm_pkg::ERR_OVERTEMP] = (temp_value > r_temp_limit);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold monitor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous_accel  <= '0;
            r_stuck_samples   <= '0;
            r_light_state     <= 1'b0;
            r_error_store     <= '0;
            r_rear_heartbeat  <= '0;
            r_temp_heartbeat  <= '0;
            r_light_heartbeat <= '0;
        end else begin
            r_previous_accel  <= n_previous_accel;
            r_stuck_samples   <= n_stuck_samples;
            r_light_state     <= n_light_state;
            r_error_store     <= n_error_store;
            r_rear_heartbeat  <= n_rear_heartbeat;
            r_temp_heartbeat  <= n_temp_heartbeat;
            r_light_heartbeat <= n_light_heartbeat;
        end
    end

    // Advance output valid: load on a sample, drop when taken
    always_comb begin
        if (sample_xfer) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Capture result payload
    always_ff @(posedge i_clk) begin
        if (sample_xfer) begin
            r_out_accel <= accel_scaled;
            r_out_brake <= brake_scaled;
        end
    end

    // Error byte and light come from the state the sample left behind
    assign o_valid          = r_out_valid;
    assign o_accel_position = r_out_accel;
    assign o_brake_position = r_out_brake;
    assign o_error_bits     = r_error_store;
    assign o_brake_light_on = r_light_state;

`ifndef ASSERT_OFF
    a_stuck_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuck_samples <= pnhm_pkg::STUCK_SAT)
        else $error("stuck counter above saturation");

    a_no_result_for_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && op != pnhm_pkg::OP_SAMPLE && !r_out_valid) |=> !o_valid)
        else $error("result produced for a non-sample item");

    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_xfer |=> (o_valid && o_error_bits == r_error_store &&
                         o_accel_position == r_previous_accel))
        else $error("sample result does not match stored state");

    a_accel_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_accel_position <= pnhm_pkg::ACCEL_CLAMP))
        else $error("accelerator position above clamp");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && o_error_bits == $past(o_error_bits)))
        else $error("stalled error byte changed");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcode 3 is not decoded by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  a;
        logic [9:0]  b;
        logic [9:0]  brake;
        logic [9:0]  level;
        logic [10:0] id;
        logic [7:0]  d0;
        logic [7:0]  d1;
    } t_node_item;

    typedef struct packed {
        logic [7:0] accel;
        logic [7:0] brake;
        logic [7:0] err;
        logic       light;
    } t_readout;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = '0;
    logic [9:0]  i_accel_pot_a = '0;
    logic [9:0]  i_accel_pot_b = '0;
    logic [9:0]  i_brake_pot = '0;
    logic [9:0]  i_brake_level_pot = '0;
    logic [10:0] i_message_id = '0;
    logic [7:0]  i_data_first = '0;
    logic [7:0]  i_data_second = '0;

    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_accel_position;
    logic [7:0]  o_brake_position;
    logic [7:0]  o_error_bits;
    logic        o_brake_light_on;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [pnhm_pkg::ADDR_W-1:0]   paddr = '0;
    logic [pnhm_pkg::DATA_W-1:0]   pwdata = '0;
    logic [pnhm_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // Items waiting to be driven, and readouts waiting to come back
    t_node_item event_backlog[$];
    t_readout   readout_backlog[$];

    int err_count = 0;
    int gen_count = 0;
    bit no_idle = 1'b0;

    // Predictor copy of the configuration
    logic [6:0]  cfg_wait = pnhm_pkg::RST_WAITING_PERIODS;
    logic [7:0]  cfg_stuck_min = pnhm_pkg::RST_STUCK_MIN_POSITION;
    logic [7:0]  cfg_stuck_lim = pnhm_pkg::RST_STUCK_SAMPLE_LIMIT;
    logic [10:0] cfg_sum_lo = pnhm_pkg::RST_POT_SUM_LOW;
    logic [10:0] cfg_sum_hi = pnhm_pkg::RST_POT_SUM_HIGH;
    logic [15:0] cfg_temp_lim = pnhm_pkg::RST_TEMP_LIMIT;

    // Predictor copy of the node state
    int         prev_accel = 0;
    int         stuck_cnt = 0;
    logic       light_st = 1'b0;
    logic [7:0] err_byte = '0;
    logic [6:0] hb_rear = '0;
    logic [6:0] hb_temp = '0;
    logic [6:0] hb_light = '0;

    pedal_and_node_health_monitor_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_accel_pot_a     (i_accel_pot_a),
        .i_accel_pot_b     (i_accel_pot_b),
        .i_brake_pot       (i_brake_pot),
        .i_brake_level_pot (i_brake_level_pot),
        .i_message_id      (i_message_id),
        .i_data_first      (i_data_first),
        .i_data_second     (i_data_second),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_accel_position  (o_accel_position),
        .o_brake_position  (o_brake_position),
        .o_error_bits      (o_error_bits),
        .o_brake_light_on  (o_brake_light_on),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 50)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    function automatic int clip(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Count one heartbeat down, or flag its timeout once it sits at zero
    function automatic logic [6:0] hb_countdown(input logic [6:0] hb, input int pos);
        if (hb == 7'd0) begin
            err_byte[pos] = 1'b1;
            return hb;
        end
        err_byte[pos] = 1'b0;
        return hb - 7'd1;
    endfunction

    // Advance the node state by one item; return 1 when a readout results
    function automatic bit front_node_step(input t_node_item it, output t_readout r);
        int accel;
        int sum;
        logic [15:0] temp;
        r = '0;
        case (it.op)
            pnhm_pkg::OP_SAMPLE: begin
                light_st = (it.brake > it.level);
                accel = it.a / 5;
                if (accel > int'(pnhm_pkg::ACCEL_CLAMP))
                    accel = int'(pnhm_pkg::ACCEL_CLAMP);
                if (accel == prev_accel && accel > int'(cfg_stuck_min))
                    stuck_cnt = stuck_cnt + 1;
                else
                    stuck_cnt = 0;
                err_byte[pnhm_pkg::ERR_STUCK] = (stuck_cnt > int'(cfg_stuck_lim));
                if (stuck_cnt > int'(pnhm_pkg::STUCK_SAT))
                    stuck_cnt = int'(pnhm_pkg::STUCK_SAT);
                prev_accel = accel;
                sum = int'(it.a) + int'(it.b);
                err_byte[pnhm_pkg::ERR_PLAUS] =
                    (sum < int'(cfg_sum_lo)) || (sum > int'(cfg_sum_hi));
                r.accel = accel[7:0];
                r.brake = 8'(it.brake / 5);
                r.err = err_byte;
                r.light = light_st;
                return 1'b1;
            end
            pnhm_pkg::OP_SECOND: begin
                hb_rear = hb_countdown(hb_rear, pnhm_pkg::ERR_REAR_TO);
                hb_temp = hb_countdown(hb_temp, pnhm_pkg::ERR_TEMP_TO);
                hb_light = hb_countdown(hb_light, pnhm_pkg::ERR_LIGHT_TO);
            end
            pnhm_pkg::OP_MESSAGE: begin
                if (it.id == pnhm_pkg::ID_REAR) begin
                    hb_rear = cfg_wait;
                    err_byte[pnhm_pkg::ERR_REAR_LO] = it.d0[1];
                    err_byte[pnhm_pkg::ERR_REAR_HI] = it.d0[2];
                    if (light_st == it.d0[0])
                        hb_light = cfg_wait;
                end
                if (it.id == pnhm_pkg::ID_TEMP) begin
                    temp = {it.d0, it.d1};
                    hb_temp = cfg_wait;
                    err_byte[pnhm_pkg::ERR_OVERTEMP] = (temp > cfg_temp_lim);
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Sender: predict on each transfer, then present the next item or idle
    always @(posedge i_clk) begin : sender
        t_node_item cur;
        t_node_item nxt;
        t_readout   r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                cur.op = i_opcode;
                cur.a = i_accel_pot_a;
                cur.b = i_accel_pot_b;
                cur.brake = i_brake_pot;
                cur.level = i_brake_level_pot;
                cur.id = i_message_id;
                cur.d0 = i_data_first;
                cur.d1 = i_data_second;
                if (front_node_step(cur, r))
                    readout_backlog.push_back(r);
            end
            if (!i_valid || o_ready) begin
                if (event_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
                    nxt = event_backlog.pop_front();
                    i_opcode <= nxt.op;
                    i_accel_pot_a <= nxt.a;
                    i_accel_pot_b <= nxt.b;
                    i_brake_pot <= nxt.brake;
                    i_brake_level_pot <= nxt.level;
                    i_message_id <= nxt.id;
                    i_data_first <= nxt.d0;
                    i_data_second <= nxt.d1;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= no_idle || ($urandom_range(0, 99) >= 32);
    end

    // Monitor: compare each readout transfer with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_readout want;
        if (i_rst_n && o_valid && i_ready) begin
            if (readout_backlog.size() == 0) begin
                report_mismatch("readout with no prediction waiting");
            end else begin
                want = readout_backlog.pop_front();
                if (o_accel_position !== want.accel)
                    report_mismatch($sformatf("accel_position got %0d want %0d",
                                              o_accel_position, want.accel));
                if (o_brake_position !== want.brake)
                    report_mismatch($sformatf("brake_position got %0d want %0d",
                                              o_brake_position, want.brake));
                if (o_error_bits !== want.err)
                    report_mismatch($sformatf("error_bits got %02h want %02h",
                                              o_error_bits, want.err));
                if (o_brake_light_on !== want.light)
                    report_mismatch($sformatf("brake_light_on got %0b want %0b",
                                              o_brake_light_on, want.light));
            end
        end
    end

    // Write one register through a setup and an access cycle
    task automatic cfg_write(input pnhm_pkg::t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pnhm_pkg::REG_WAITING_PERIODS:    cfg_wait = val[6:0];
            pnhm_pkg::REG_STUCK_MIN_POSITION: cfg_stuck_min = val[7:0];
            pnhm_pkg::REG_STUCK_SAMPLE_LIMIT: cfg_stuck_lim = val[7:0];
            pnhm_pkg::REG_POT_SUM_LOW:        cfg_sum_lo = val[10:0];
            pnhm_pkg::REG_POT_SUM_HIGH:       cfg_sum_hi = val[10:0];
            pnhm_pkg::REG_TEMP_LIMIT:         cfg_temp_lim = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input int w, input int mn, input int lm,
                               input int lo, input int hi, input int tl);
        cfg_write(pnhm_pkg::REG_WAITING_PERIODS, w);
        cfg_write(pnhm_pkg::REG_STUCK_MIN_POSITION, mn);
        cfg_write(pnhm_pkg::REG_STUCK_SAMPLE_LIMIT, lm);
        cfg_write(pnhm_pkg::REG_POT_SUM_LOW, lo);
        cfg_write(pnhm_pkg::REG_POT_SUM_HIGH, hi);
        cfg_write(pnhm_pkg::REG_TEMP_LIMIT, tl);
        @(negedge i_clk);
    endtask

    // Hold until every item is out and every readout is back, then settle
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (event_backlog.size() != 0 || i_valid || readout_backlog.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_node_item rand_item();
        t_node_item it;
        it.op = 2'($urandom_range(0, 3));
        it.a = 10'($urandom_range(0, 1023));
        it.b = 10'($urandom_range(0, 1023));
        it.brake = 10'($urandom_range(0, 1023));
        it.level = 10'($urandom_range(0, 1023));
        it.id = 11'($urandom_range(0, 2047));
        it.d0 = 8'($urandom_range(0, 255));
        it.d1 = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic push_sample(input int a, input int b, input int brake, input int level);
        t_node_item it;
        it = rand_item();
        it.op = pnhm_pkg::OP_SAMPLE;
        it.a = a[9:0];
        it.b = b[9:0];
        it.brake = brake[9:0];
        it.level = level[9:0];
        event_backlog.push_back(it);
        gen_count++;
    endtask

    task automatic push_second();
        t_node_item it;
        it = rand_item();
        it.op = pnhm_pkg::OP_SECOND;
        event_backlog.push_back(it);
        gen_count++;
    endtask

    task automatic push_message(input logic [10:0] id, input logic [7:0] d0,
                                input logic [7:0] d1);
        t_node_item it;
        it = rand_item();
        it.op = pnhm_pkg::OP_MESSAGE;
        it.id = id;
        it.d0 = d0;
        it.d1 = d1;
        event_backlog.push_back(it);
        gen_count++;
    endtask

    // Second pot reading, often right at an edge of the plausibility window
    function automatic int pick_pot_b(input int a);
        case ($urandom_range(0, 3))
            0: return clip(int'(cfg_sum_lo) - a + int'($urandom_range(0, 2)) - 1, 1023);
            1: return clip(int'(cfg_sum_hi) - a + int'($urandom_range(0, 2)) - 1, 1023);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    task automatic push_random_sample(input int a);
        int lvl;
        int brk;
        lvl = $urandom_range(0, 1023);
        if ($urandom_range(0, 1))
            brk = clip(lvl + int'($urandom_range(0, 2)) - 1, 1023);
        else
            brk = $urandom_range(0, 1023);
        push_sample(a, pick_pot_b(a), brk, lvl);
    endtask

    // Temperature, often right at the limit
    function automatic logic [15:0] pick_temp();
        if ($urandom_range(0, 1))
            return 16'(clip(int'(cfg_temp_lim) + int'($urandom_range(0, 2)) - 1, 65535));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Random traffic: pedal runs, heartbeat sequences, ticks and noise
    task automatic run_random(input int n, input bit long_run);
        int kind;
        int len;
        int v;
        int base;
        logic [15:0] tv;
        t_node_item it;
        @(negedge i_clk);
        if (long_run) begin
            // Hold the pedal in one position long enough to saturate the count
            v = $urandom_range(int'(cfg_stuck_min) + 1, 200);
            repeat (135) push_random_sample(clip(v * 5 + int'($urandom_range(0, 4)), 1023));
        end
        gen_count = 0;
        while (gen_count < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                len = $urandom_range(1, 8);
                base = $urandom_range(0, 1023);
                repeat (len) begin
                    if ($urandom_range(0, 2) == 0)
                        base = $urandom_range(0, 1023);
                    push_random_sample(clip(base - base % 5 + int'($urandom_range(0, 4)), 1023));
                end
            end else if (kind < 65) begin
                if ($urandom_range(0, 1)) begin
                    push_message(pnhm_pkg::ID_REAR, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                end else begin
                    tv = pick_temp();
                    push_message(pnhm_pkg::ID_TEMP, tv[15:8], tv[7:0]);
                end
                len = $urandom_range(0, clip(int'(cfg_wait) + 2, 10));
                repeat (len) begin
                    if ($urandom_range(0, 2) == 0)
                        push_random_sample($urandom_range(0, 1023));
                    else
                        push_second();
                end
                push_random_sample($urandom_range(0, 1023));
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 3)) push_second();
                push_random_sample($urandom_range(0, 1023));
            end else begin
                it = rand_item();
                case ($urandom_range(0, 3))
                    0: it.id = pnhm_pkg::ID_REAR;
                    1: it.id = pnhm_pkg::ID_TEMP;
                    default: ;
                endcase
                event_backlog.push_back(it);
                if (it.op != OP_UNUSED)
                    gen_count++;
            end
        end
    endtask

    initial begin : stimulus
        t_node_item it;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, window edges, clamp, every opcode, messages
        push_sample(0, 0, 0, 0);
        push_sample(1023, 1023, 1023, 0);
        push_sample(1000, 323, 512, 511);
        push_sample(1004, 0, 511, 512);
        push_sample(722, 1, 300, 300);
        push_sample(722, 0, 0, 1023);
        push_sample(1000, 324, 1023, 1022);
        it = rand_item();
        it.op = OP_UNUSED;
        event_backlog.push_back(it);
        push_second();
        push_message(pnhm_pkg::ID_REAR, 8'h07, 8'h00);
        push_message(pnhm_pkg::ID_TEMP, 8'h02, 8'h59);
        push_sample(500, 500, 10, 20);
        push_second();
        push_sample(500, 500, 10, 20);
        push_message(pnhm_pkg::ID_REAR, 8'h01, 8'hff);
        push_message(pnhm_pkg::ID_TEMP, 8'h02, 8'h58);
        push_message(pnhm_pkg::ID_REAR + 11'd1, 8'hff, 8'hff);
        push_message(11'h7ff, 8'hff, 8'hff);
        push_second();
        push_sample(1023, 0, 1023, 1023);
        repeat (6) push_second();
        push_sample(400, 600, 5, 4);
        run_random(55, 1'b0);
        wait_drained();

        // Low extremes
        load_config(1, 0, 0, 0, 2046, 0);
        run_random(45, 1'b0);
        wait_drained();

        // High extremes, sender and receiver never idle
        load_config(127, 200, 129, 2046, 2046, 65535);
        no_idle = 1'b1;
        run_random(45, 1'b0);
        wait_drained();
        no_idle = 1'b0;

        // Zero reload, random thresholds
        load_config(0, $urandom_range(0, 200), $urandom_range(0, 129),
                    $urandom_range(0, 2046), $urandom_range(0, 2046),
                    $urandom_range(0, 65535));
        run_random(35, 1'b0);
        wait_drained();

        // Top stuck limit, reached only at the saturated count
        load_config($urandom_range(1, 10), $urandom_range(0, 100), 129,
                    int'(pnhm_pkg::RST_POT_SUM_LOW), int'(pnhm_pkg::RST_POT_SUM_HIGH),
                    int'(pnhm_pkg::RST_TEMP_LIMIT));
        run_random(45, 1'b1);
        wait_drained();

        // Back to reset values
        load_config(int'(pnhm_pkg::RST_WAITING_PERIODS),
                    int'(pnhm_pkg::RST_STUCK_MIN_POSITION),
                    int'(pnhm_pkg::RST_STUCK_SAMPLE_LIMIT),
                    int'(pnhm_pkg::RST_POT_SUM_LOW), int'(pnhm_pkg::RST_POT_SUM_HIGH),
                    int'(pnhm_pkg::RST_TEMP_LIMIT));
        run_random(35, 1'b0);
        wait_drained();

        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
